>>> src/pfdc_pkg.sv
// ============================================================================
// pfdc_pkg: shared types and constants for the Playfair digraph cipher
// Operation and status codes, beat structs and square geometry.
// ============================================================================
package pfdc_pkg;

  localparam int GRID_SIDE = 5;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int LETTERS   = 26;

  localparam int LETTER_W = 5;
  localparam int POS_W    = $clog2(CELLS + 1);
  localparam int COORD_W  = 3;

  localparam logic [2:0] OP_KEY     = 3'd0;
  localparam logic [2:0] OP_FINISH  = 3'd1;
  localparam logic [2:0] OP_ENCRYPT = 3'd2;
  localparam logic [2:0] OP_DECRYPT = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_PHASE   = 2'd2;
  localparam logic [1:0] ST_OMITTED = 2'd3;

  localparam logic [LETTER_W-1:0] OMIT_RESET = 5'd16;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic [2:0]          operation;
    logic [7:0]          key_byte;
    logic [LETTER_W-1:0] first_letter;
    logic [LETTER_W-1:0] second_letter;
  } item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] first_out;
    logic [LETTER_W-1:0] second_out;
    logic [1:0]          status;
  } result_t;

endpackage

>>> src/playfair_digraph_cipher.sv
// ============================================================================
// playfair_digraph_cipher: Playfair square builder and digraph cipher
// Builds the 5x5 square from key bytes and ciphers letter pairs.
// ============================================================================
// Path from accept to result valid: key byte, clear and flagged items go through
// the done state to the result register; cipher pairs read row/column, then the square,
// before the done state; finish walks 26 letters, one per cycle through the fill sequencer.
// One item at a time: the next beat is taken the cycle after the result loads.
// A stalled result holds the next one.
// Synchronous reset empties the square and sets the omitted letter to Q.
module playfair_digraph_cipher (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [4:0]             cfg_data,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  pfdc_pkg::item_t        item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output pfdc_pkg::result_t      result
);
  import pfdc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_LOOK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                state;
  logic [LETTER_W-1:0]   omitted;
  logic [LETTERS-1:0]    placed;
  logic [POS_W-1:0]      fill_pos;
  logic [COORD_W-1:0]    fill_row;
  logic [COORD_W-1:0]    fill_col;
  logic                  square_ready;
  logic [LETTER_W-1:0]   fill_letter;
  logic                  op_dec;
  logic                  res_pair;
  logic [1:0]            res_status;

  logic [LETTER_W-1:0]   square_mem [CELLS];
  logic [2*COORD_W-1:0]  coord_mem [LETTERS];
  logic [2*COORD_W-1:0]  coord_a;
  logic [2*COORD_W-1:0]  coord_b;
  logic [LETTER_W-1:0]   sq_rd1;
  logic [LETTER_W-1:0]   sq_rd2;

  logic                  accept;
  logic                  key_upper;
  logic                  key_lower;
  logic                  key_is_letter;
  logic [LETTER_W-1:0]   key_letter;
  logic                  key_ok;
  logic                  a_ok;
  logic                  b_ok;
  logic                  fill_room;
  logic                  place_en;
  logic [LETTER_W-1:0]   place_letter;
  logic [POS_W-1:0]      idx1;
  logic [POS_W-1:0]      idx2;

  function automatic logic [COORD_W-1:0] wrap_step(input logic [COORD_W-1:0] v,
                                                   input logic dec);
    logic [COORD_W-1:0] r;
    if (dec) begin
      r = (v == '0) ? COORD_W'(GRID_SIDE - 1) : v - 1'b1;
    end else begin
      r = (v == COORD_W'(GRID_SIDE - 1)) ? '0 : v + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] cell_index(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
    logic [POS_W-1:0] r5;
    r5 = POS_W'({row, 2'b00}) + POS_W'(row);
    return r5 + POS_W'(col);
  endfunction

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign fill_room  = (fill_pos < POS_W'(CELLS));

  always_comb begin
    key_upper     = (item.key_byte >= ASCII_UPPER_A) && (item.key_byte <= ASCII_UPPER_Z);
    key_lower     = (item.key_byte >= ASCII_LOWER_A) && (item.key_byte <= ASCII_LOWER_Z);
    key_is_letter = key_upper || key_lower;
    key_letter    = key_upper ? LETTER_W'(item.key_byte - ASCII_UPPER_A)
                              : LETTER_W'(item.key_byte - ASCII_LOWER_A);
    key_ok        = key_is_letter && (key_letter != omitted) && !placed[key_letter] &&
                    fill_room;
    a_ok = (item.first_letter < LETTER_W'(LETTERS)) && (item.first_letter != omitted) &&
           placed[item.first_letter];
    b_ok = (item.second_letter < LETTER_W'(LETTERS)) && (item.second_letter != omitted) &&
           placed[item.second_letter];
  end

  always_comb begin
    place_en     = 1'b0;
    place_letter = fill_letter;
    if (state == S_IDLE) begin
      place_en     = accept && (item.operation == OP_KEY) && !square_ready && key_ok;
      place_letter = key_letter;
    end else if (state == S_FILL) begin
      place_en = (fill_letter != omitted) && !placed[fill_letter] && fill_room;
    end
  end

  always_comb begin
    logic [COORD_W-1:0] r1, c1, r2, c2;
    {r1, c1} = coord_a;
    {r2, c2} = coord_b;
    if (r1 == r2) begin
      idx1 = cell_index(r1, wrap_step(c1, op_dec));
      idx2 = cell_index(r2, wrap_step(c2, op_dec));
    end else if (c1 == c2) begin
      idx1 = cell_index(wrap_step(r1, op_dec), c1);
      idx2 = cell_index(wrap_step(r2, op_dec), c2);
    end else begin
      idx1 = cell_index(r1, c2);
      idx2 = cell_index(r2, c1);
    end
  end

  always_ff @(posedge clk) begin
    if (place_en) begin
      square_mem[fill_pos[POS_W-1:0]] <= place_letter;
      coord_mem[place_letter]         <= {fill_row, fill_col};
    end
    if (state == S_IDLE && accept && (item.operation == OP_ENCRYPT ||
        item.operation == OP_DECRYPT) && square_ready && a_ok && b_ok) begin
      coord_a <= coord_mem[item.first_letter];
      coord_b <= coord_mem[item.second_letter];
    end
    if (state == S_LOOK) begin
      sq_rd1 <= square_mem[idx1];
      sq_rd2 <= square_mem[idx2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      omitted      <= OMIT_RESET;
      placed       <= '0;
      fill_pos     <= '0;
      fill_row     <= '0;
      fill_col     <= '0;
      square_ready <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        omitted <= cfg_data;
      end
      if (state == S_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (place_en) begin
        placed[place_letter] <= 1'b1;
        fill_pos             <= fill_pos + 1'b1;
        if (fill_col == COORD_W'(GRID_SIDE - 1)) begin
          fill_col <= '0;
          fill_row <= fill_row + 1'b1;
        end else begin
          fill_col <= fill_col + 1'b1;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (item.operation)
              OP_KEY: begin
                state <= S_DONE;
              end
              OP_FINISH: begin
                state <= square_ready ? S_DONE : S_FILL;
              end
              OP_ENCRYPT, OP_DECRYPT: begin
                state <= (square_ready && a_ok && b_ok) ? S_LOOK : S_DONE;
              end
              OP_CLEAR: begin
                placed       <= '0;
                fill_pos     <= '0;
                fill_row     <= '0;
                fill_col     <= '0;
                square_ready <= 1'b0;
                state        <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_FILL: begin
          if (fill_letter == LETTER_W'(LETTERS - 1)) begin
            square_ready <= 1'b1;
            state        <= S_DONE;
          end
        end
        S_LOOK: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      op_dec      <= (item.operation == OP_DECRYPT);
      res_pair    <= (item.operation == OP_ENCRYPT || item.operation == OP_DECRYPT) &&
                     square_ready && a_ok && b_ok;
      fill_letter <= '0;
      unique case (item.operation)
        OP_KEY: begin
          if (square_ready) begin
            res_status <= ST_PHASE;
          end else if (!key_ok) begin
            res_status <= ST_IGNORED;
          end else begin
            res_status <= ST_DONE;
          end
        end
        OP_FINISH: begin
          res_status <= square_ready ? ST_PHASE : ST_DONE;
        end
        OP_ENCRYPT, OP_DECRYPT: begin
          if (!square_ready) begin
            res_status <= ST_PHASE;
          end else if (!(a_ok && b_ok)) begin
            res_status <= ST_OMITTED;
          end else begin
            res_status <= ST_DONE;
          end
        end
        OP_CLEAR: begin
          res_status <= ST_DONE;
        end
        default: begin
          res_status <= ST_PHASE;
        end
      endcase
    end else if (state == S_FILL) begin
      fill_letter <= fill_letter + 1'b1;
    end
    if (state == S_DONE && (!result_valid || !result_stall)) begin
      result.first_out  <= res_pair ? sq_rd1 : '0;
      result.second_out <= res_pair ? sq_rd2 : '0;
      result.status     <= res_status;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_pos <= POS_W'(CELLS))
    else $error("fill position past end of square");

  a_placed_count: assert property (@(posedge clk) disable iff (rst)
    $countones(placed) == int'(fill_pos))
    else $error("placed flags disagree with fill position");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    square_ready |-> fill_pos == POS_W'(CELLS))
    else $error("square marked ready while not full");

  a_fill_coord: assert property (@(posedge clk) disable iff (rst)
    fill_pos == POS_W'(int'(fill_row) * GRID_SIDE + int'(fill_col)))
    else $error("fill row and column disagree with fill position");

endmodule
